FILE: hw/rtl/ubxr_pkg.sv
// ubxr_pkg: shared types and constants of the sync-framed byte receiver
// used by ubxr_parser, ubxr_out_buf and ubx_frame_receiver; no dependencies

package ubxr_pkg;

  // framing bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // reset value of the payload length limit
  localparam logic [15:0] MAX_LEN_RESET = 16'd400;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_MAX_LEN = 1'b0;  // word index of max_payload_length

  // result kinds
  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_CK_GOOD = 2'd1,
    EV_CK_BAD  = 2'd2,
    EV_LEN_REJ = 2'd3
  } ubxr_event_t;

  // receiver phase, one-hot
  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LENLO   = 9'b000010000,
    PH_LENHI   = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CKLO    = 9'b010000000,
    PH_CKHI    = 9'b100000000
  } ubxr_phase_t;

  // one result item
  typedef struct packed {
    ubxr_event_t event_kind;
    logic [7:0]  message_class;
    logic [7:0]  message_id;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
  } ubxr_result_t;

endpackage

FILE: hw/rtl/ubxr_parser.sv
// ubxr_parser: frame state machine, running checksums and result forming
// depends on ubxr_pkg

module ubxr_parser
  import ubxr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   byte_in,
  input  logic [15:0]  max_len,
  output logic         push,
  output ubxr_result_t result
);

  ubxr_phase_t phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  ck_lo_r, ck_lo_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] new_len;
  logic [15:0] count_inc;

  // running fletcher sums with the current byte folded in
  assign add_a     = sum_a_r + byte_in;
  assign add_b     = sum_b_r + add_a;
  assign new_len   = {byte_in, len_lo_r};
  assign count_inc = (count_r == 16'hFFFF) ? count_r : count_r + 16'd1;

  // next state and result for one byte
  always_comb begin
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    ck_lo_nxt  = ck_lo_r;
    push       = 1'b0;
    result.event_kind    = EV_PAYLOAD;
    result.message_class = class_r;
    result.message_id    = id_r;
    result.frame_length  = len_r;
    result.payload_byte  = 8'd0;
    result.payload_index = 16'd0;
    unique case (phase_r)
      PH_SYNC2: begin
        if (byte_in == SYNC_SECOND) begin
          phase_nxt = PH_CLASS;
        end else if (byte_in != SYNC_FIRST) begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        class_nxt = byte_in;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = byte_in;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_lo_nxt = byte_in;
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        phase_nxt  = PH_LENHI;
      end
      PH_LENHI: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        len_nxt   = new_len;
        count_nxt = 16'd0;
        if (new_len > max_len) begin
          push                = accept;
          result.event_kind   = EV_LEN_REJ;
          result.frame_length = new_len;
          phase_nxt           = PH_SYNC1;
        end else if (new_len == 16'd0) begin
          phase_nxt = PH_CKLO;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        push                 = accept;
        result.payload_byte  = byte_in;
        result.payload_index = count_r;
        sum_a_nxt            = add_a;
        sum_b_nxt            = add_b;
        count_nxt            = count_inc;
        if (count_inc >= len_r) begin
          phase_nxt = PH_CKLO;
        end
      end
      PH_CKLO: begin
        ck_lo_nxt = byte_in;
        phase_nxt = PH_CKHI;
      end
      PH_CKHI: begin
        push              = accept;
        result.event_kind = (sum_a_r == ck_lo_r && sum_b_r == byte_in) ? EV_CK_GOOD
                                                                       : EV_CK_BAD;
        phase_nxt         = PH_SYNC1;
      end
      // hunting for the first sync byte
      default: begin
        if (byte_in == SYNC_FIRST) begin
          sum_a_nxt = 8'd0;
          sum_b_nxt = 8'd0;
          count_nxt = 16'd0;
          phase_nxt = PH_SYNC2;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
    endcase
  end

  // state advances only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      class_r  <= 8'd0;
      id_r     <= 8'd0;
      len_lo_r <= 8'd0;
      len_r    <= 16'd0;
      count_r  <= 16'd0;
      sum_a_r  <= 8'd0;
      sum_b_r  <= 8'd0;
      ck_lo_r  <= 8'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      ck_lo_r  <= ck_lo_nxt;
    end
  end

endmodule

FILE: hw/rtl/ubxr_out_buf.sv
// ubxr_out_buf: result register with a skid stage behind it
// depends on ubxr_pkg

module ubxr_out_buf
  import ubxr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ubxr_result_t push_data,
  input  logic         out_stall,
  output logic         out_valid,
  output ubxr_result_t out_data,
  output logic         full
);

  logic         out_valid_r;
  logic         skid_valid_r;
  ubxr_result_t out_data_r;
  ubxr_result_t skid_data_r;
  logic         pop;

  assign pop       = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

endmodule

FILE: hw/rtl/ubx_frame_receiver.sv
// ubx_frame_receiver: top level of the sync-framed byte receiver
// depends on ubxr_pkg, ubxr_parser and ubxr_out_buf
//
// Usage:
//   in_*  channel carries one received byte per transfer (in_valid/in_stall).
//   out_* channel carries at most one result per byte: a payload byte with its
//   index, a checksum good/bad frame end, or a length-rejected notice.
//   APB port holds max_payload_length at byte address 0 (reset 400); write it
//   only while no transfer is in flight.
// Timing:
//   one byte is taken every cycle while in_stall is low; a result-yielding byte
//   goes to the result register, or to the skid stage while that register holds.
//   The frame state machine updates in the same cycle as the transfer.
// Reset (rst_n low, synchronous): back to hunting for the first sync byte,
//   sums and counters cleared, output empty, limit restored to 400.
// Receiver stall: the result register holds; one more result is caught in a
//   skid stage, after which in_stall rises until the result register drains.

module ubx_frame_receiver
  import ubxr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input byte channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_kind,
  output logic [7:0]            out_message_class,
  output logic [7:0]            out_message_id,
  output logic [15:0]           out_frame_length,
  output logic [7:0]            out_payload_byte,
  output logic [15:0]           out_payload_index,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [15:0]  max_len_r;
  logic         in_accept;
  logic         push;
  logic         buf_full;
  ubxr_result_t push_data;
  ubxr_result_t out_data;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[CFG_ADDR_W-1] == REG_MAX_LEN) begin
      max_len_r <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_MAX_LEN)
                  ? {{(CFG_DATA_W-16){1'b0}}, max_len_r} : '0;

  // input transfer
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  ubxr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .byte_in (in_byte_in),
    .max_len (max_len_r),
    .push    (push),
    .result  (push_data)
  );

  ubxr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  // result fields
  assign out_event_kind    = out_data.event_kind;
  assign out_message_class = out_data.message_class;
  assign out_message_id    = out_data.message_id;
  assign out_frame_length  = out_data.frame_length;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_index = out_data.payload_index;

`ifndef SYNTHESIS
  // out_valid is high on the next cycle after a result is produced
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("result lost after push");

  // skid stage only fills behind a full result register
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid stage holds data with empty result register");

  // a result arriving at a stalled full register lands in the skid stage
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid && out_stall) |=> in_stall)
    else $error("result not caught by skid stage");
`endif

endmodule

FILE: verif/ubx_frame_receiver_tb.sv
// testbench for ubx_frame_receiver: byte stream in, payload and frame-end results out
// keeps its own model of the framing state machine and checks every result transfer
// depends on ubxr_pkg and the ubx_frame_receiver rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ubxr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_BYTES    = 190;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_LEN = {REG_MAX_LEN, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED  = {~REG_MAX_LEN, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_byte_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_event_kind;
  logic [7:0]            out_message_class;
  logic [7:0]            out_message_id;
  logic [15:0]           out_frame_length;
  logic [7:0]            out_payload_byte;
  logic [15:0]           out_payload_index;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // receiver model state
  ubxr_phase_t  rx_phase;
  logic [7:0]   rx_class, rx_id, rx_len_lo, rx_sum_a, rx_sum_b, rx_ck_lo;
  logic [15:0]  rx_len, rx_count, rx_max_len;
  ubxr_result_t pending_events[$];

  // run bookkeeping
  int fail_count  = 0;
  int n_bytes     = 0;
  int n_payload   = 0;
  int n_good      = 0;
  int n_bad       = 0;
  int n_rejected  = 0;
  int frame_bytes = 0;
  bit src_no_gaps = 1'b0;
  bit sink_free   = 1'b0;
  bit hold_req    = 1'b0;

  ubx_frame_receiver u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // running fletcher sums of the model
  function automatic void fold_sum(input logic [7:0] b);
    rx_sum_a = rx_sum_a + b;
    rx_sum_b = rx_sum_b + rx_sum_a;
  endfunction

  // advance the model by one byte; returns 1 when the byte yields a result
  function automatic bit predict_byte(input logic [7:0] b, output ubxr_result_t ev);
    bit hit;
    hit = 1'b0;
    ev  = '0;
    case (rx_phase)
      PH_SYNC2: begin
        if (b == SYNC_SECOND) rx_phase = PH_CLASS;
        else if (b != SYNC_FIRST) rx_phase = PH_SYNC1;
      end
      PH_CLASS: begin
        rx_class = b;
        fold_sum(b);
        rx_phase = PH_ID;
      end
      PH_ID: begin
        rx_id = b;
        fold_sum(b);
        rx_phase = PH_LENLO;
      end
      PH_LENLO: begin
        rx_len_lo = b;
        fold_sum(b);
        rx_phase = PH_LENHI;
      end
      PH_LENHI: begin
        fold_sum(b);
        rx_len   = {b, rx_len_lo};
        rx_count = '0;
        if (rx_len > rx_max_len) begin
          hit = 1'b1;
          ev.event_kind = EV_LEN_REJ;
          rx_phase = PH_SYNC1;
        end else if (rx_len == 16'd0) begin
          rx_phase = PH_CKLO;
        end else begin
          rx_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        hit = 1'b1;
        ev.event_kind    = EV_PAYLOAD;
        ev.payload_byte  = b;
        ev.payload_index = rx_count;
        fold_sum(b);
        if (rx_count != 16'hFFFF) rx_count = rx_count + 16'd1;
        if (rx_count >= rx_len) rx_phase = PH_CKLO;
      end
      PH_CKLO: begin
        rx_ck_lo = b;
        rx_phase = PH_CKHI;
      end
      PH_CKHI: begin
        hit = 1'b1;
        ev.event_kind = (rx_sum_a == rx_ck_lo && rx_sum_b == b) ? EV_CK_GOOD : EV_CK_BAD;
        rx_phase = PH_SYNC1;
      end
      default: begin
        // hunting: a first sync byte starts a new frame
        if (b == SYNC_FIRST) begin
          rx_sum_a = '0;
          rx_sum_b = '0;
          rx_count = '0;
          rx_phase = PH_SYNC2;
        end else begin
          rx_phase = PH_SYNC1;
        end
      end
    endcase
    ev.message_class = rx_class;
    ev.message_id    = rx_id;
    ev.frame_length  = rx_len;
    return hit;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // model update, result checking and limit tracking, all on sampled values
  always @(posedge clk) begin : track_results
    ubxr_result_t ev;
    ubxr_result_t want;
    if (rst_n !== 1'b1) begin
      rx_phase   = PH_SYNC1;
      rx_class   = '0;
      rx_id      = '0;
      rx_len_lo  = '0;
      rx_len     = '0;
      rx_count   = '0;
      rx_sum_a   = '0;
      rx_sum_b   = '0;
      rx_ck_lo   = '0;
      rx_max_len = MAX_LEN_RESET;
      pending_events.delete();
    end else begin
      // result transfer
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_events.size() == 0) begin
          $error("unexpected result: kind %0d class %0h id %0h", out_event_kind,
                 out_message_class, out_message_id);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", 16'(want.event_kind), 16'(out_event_kind));
          check_field("message_class", 16'(want.message_class), 16'(out_message_class));
          check_field("message_id", 16'(want.message_id), 16'(out_message_id));
          check_field("frame_length", want.frame_length, out_frame_length);
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
          check_field("payload_index", want.payload_index, out_payload_index);
          case (want.event_kind)
            EV_PAYLOAD: n_payload++;
            EV_CK_GOOD: n_good++;
            EV_CK_BAD:  n_bad++;
            default:    n_rejected++;
          endcase
        end
      end
      // byte transfer
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        n_bytes++;
        if (predict_byte(in_byte_in, ev)) pending_events.push_back(ev);
      end
      // register write
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_MAX_LEN)
        rx_max_len = pwdata[15:0];
    end
  end

  // watchdog: too many cycles without any transfer ends the run
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit no_gaps);
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver side: random stall, free running stretches, one long hold-off
  initial begin : sink_stall
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!sink_free && $urandom_range(0, 2) == 0) stall_left = pick_gap(1'b0);
      end
    end
  end

  // one byte transfer, after a random gap
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(src_no_gaps);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb access; a read is compared with the limit the model holds
  task automatic cfg_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (!wr) check_field("max_payload_length", rx_max_len, got[15:0]);
  endtask

  task automatic set_limit(input logic [15:0] limit);
    drain();
    cfg_access(1'b1, ADDR_MAX_LEN, {16'($urandom), limit});
  endtask

  // sends one frame; oversize frames stop after the header, cut_at truncates
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input bit dup_sync, input bit bad_ck,
                            input bit edge_fill, input int cut_at);
    logic [7:0] bytes[$];
    logic [7:0] hdr[4];
    logic [7:0] a, bb, p;
    int last;
    a = '0;
    bb = '0;
    hdr = '{cls, id, len[7:0], len[15:8]};
    bytes.push_back(SYNC_FIRST);
    if (dup_sync) bytes.push_back(SYNC_FIRST);
    bytes.push_back(SYNC_SECOND);
    for (int i = 0; i < 4; i++) begin
      bytes.push_back(hdr[i]);
      a  = a + hdr[i];
      bb = bb + a;
    end
    if (len <= rx_max_len) begin
      for (int i = 0; i < int'(len); i++) begin
        p = edge_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
        bytes.push_back(p);
        a  = a + p;
        bb = bb + a;
      end
      if (bad_ck) begin
        if ($urandom_range(0, 1) == 0) a = a ^ 8'($urandom_range(1, 255));
        else bb = bb ^ 8'($urandom_range(1, 255));
      end
      bytes.push_back(a);
      bytes.push_back(bb);
    end
    last = (cut_at >= 0 && cut_at < bytes.size()) ? cut_at : bytes.size();
    for (int i = 0; i < last; i++) push_byte(bytes[i]);
    frame_bytes += last;
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'($urandom_range(0, 8));
    if (r < 92 || rx_max_len == 16'hFFFF) return 16'($urandom_range(9, 40));
    return 16'($urandom_range(int'(rx_max_len) + 1, 65535));
  endfunction

  // repeated sync, wrong second sync, empty payload with bad checksum, length reject
  task automatic test_directed_frames();
    send_frame(8'hFF, 8'h00, 16'd2, 1'b1, 1'b0, 1'b1, -1);
    push_byte(SYNC_FIRST);
    push_byte(8'h00);
    send_frame(8'h01, 8'hFF, 16'd0, 1'b0, 1'b1, 1'b0, -1);
    send_frame(8'h05, 8'h06, 16'hFFFF, 1'b0, 1'b0, 1'b0, -1);
    drain();
  endtask

  // reset value, unused address, length equal to and just over the limit
  task automatic test_limit_register();
    cfg_access(1'b0, ADDR_MAX_LEN, '0);
    cfg_access(1'b1, ADDR_UNUSED, 32'h0);
    cfg_access(1'b0, ADDR_MAX_LEN, '0);
    set_limit(16'd3);
    cfg_access(1'b0, ADDR_MAX_LEN, '0);
    send_frame(8'h10, 8'h20, 16'd3, 1'b0, 1'b0, 1'b0, -1);
    send_frame(8'h10, 8'h21, 16'd4, 1'b0, 1'b0, 1'b0, -1);
    set_limit(16'd0);
    send_frame(8'h30, 8'h40, 16'd0, 1'b0, 1'b0, 1'b0, -1);
    send_frame(8'h30, 8'h41, 16'd1, 1'b0, 1'b0, 1'b0, -1);
    set_limit(16'hFFFF);
    cfg_access(1'b0, ADDR_MAX_LEN, '0);
    send_frame(8'h50, 8'h60, 16'd5, 1'b0, 1'b0, 1'b0, -1);
    set_limit(MAX_LEN_RESET);
    drain();
  endtask

  // receiver holds off while a long frame streams in back to back
  task automatic test_backpressure();
    src_no_gaps = 1'b1;
    hold_req    = 1'b1;
    send_frame(8'($urandom), 8'($urandom), 16'd60, 1'b0, 1'b0, 1'b0, -1);
    drain();
    src_no_gaps = 1'b0;
  endtask

  // mostly well-formed frames with random content, plus broken frames and noise
  task automatic test_random_stream();
    logic [15:0] limits[5];
    int r, target;
    limits = '{MAX_LEN_RESET, 16'd16, 16'd0, 16'hFFFF, 16'($urandom_range(1, 64))};
    foreach (limits[k]) begin
      set_limit(limits[k]);
      target = frame_bytes + PHASE_BYTES;
      while (frame_bytes < target) begin
        if ($urandom_range(0, 15) == 0) src_no_gaps = !src_no_gaps;
        if ($urandom_range(0, 15) == 0) sink_free = !sink_free;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_frame(8'($urandom), 8'($urandom), pick_len(), $urandom_range(0, 7) == 0,
                     1'b0, 1'b0, -1);
        end else if (r < 82) begin
          send_frame(8'($urandom), 8'($urandom), pick_len(), 1'b0, 1'b1, 1'b0, -1);
        end else if (r < 92) begin
          send_frame(8'($urandom), 8'($urandom), pick_len(), 1'b0, 1'b0, 1'b0,
                     $urandom_range(1, 9));
        end else begin
          repeat ($urandom_range(1, 6))
            push_byte(($urandom_range(0, 7) == 0) ? SYNC_FIRST : 8'($urandom));
        end
      end
    end
    src_no_gaps = 1'b0;
    sink_free   = 1'b0;
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte_in = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_limit_register();
    test_backpressure();
    test_random_stream();
    drain();

    $display("run: %0d bytes in, %0d payload bytes, %0d good and %0d bad frames",
             n_bytes, n_payload, n_good, n_bad);
    $display("run: %0d length rejects over limits 400, 16, 0, 65535 and random",
             n_rejected);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
